>>> rtl/core/rrgc_pkg.sv
package rrgc_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned GainW    = 16;
  localparam int unsigned WidthW   = 13;
  localparam int unsigned BoundW   = 12;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 5;

  localparam logic [GainW-1:0] GAIN_ONE = 16'd256;
  localparam logic [ChanW-1:0] CHAN_MAX = 8'd255;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH = 3'd0,
    REG_COL_FIRST   = 3'd1,
    REG_COL_LAST    = 3'd2,
    REG_ROW_FIRST   = 3'd3,
    REG_ROW_LAST    = 3'd4,
    REG_GAIN_RED    = 3'd5,
    REG_GAIN_GREEN  = 3'd6,
    REG_GAIN_BLUE   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic             frame_start;
    logic [ChanW-1:0] blue_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] red_in;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] blue_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] red_out;
    logic             in_region;
  } pix_out_t;

endpackage

>>> rtl/core/rrgc_gain.sv
module rrgc_gain (
  input  logic [rrgc_pkg::ChanW-1:0] chan_i,
  input  logic [rrgc_pkg::GainW-1:0] gain_i,
  output logic [rrgc_pkg::ChanW-1:0] chan_o
);
  import rrgc_pkg::*;

  logic [ChanW-1:0]       v;
  logic [ChanW+GainW-1:0] prod;

  always_comb begin
    v = chan_i;
    if (chan_i == '0 && gain_i != GAIN_ONE) begin
      v = ChanW'(1);
    end
    prod = (ChanW+GainW)'(v) * (ChanW+GainW)'(gain_i);
    if (prod[ChanW+GainW-1:2*ChanW] != '0) begin
      chan_o = CHAN_MAX;
    end else begin
      chan_o = prod[2*ChanW-1:ChanW];
    end
  end

endmodule

>>> rtl/core/region_rgb_gain_clamp.sv
// Applies a separate unsigned 8.8 gain to the red, green and blue channels of
// every pixel inside a programmable rectangle of a raster stream, truncating
// and saturating each channel at 255; pixels outside pass unchanged with
// in_region low. Pixels arrive row by row, left to right, and a pixel
// with frame_start set is taken as column 0, row 0. One pixel is accepted
// every clock while the output is not stalled; each pixel passes through the
// position and region stage and then the three gain multipliers that feed
// the output register. Registers on the APB port must be written by the user
// only while no pixel is in flight; the block itself does not enforce this.
module region_rgb_gain_clamp #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rrgc_pkg::pix_in_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rrgc_pkg::pix_out_t            out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrgc_pkg::ApbAddrW-1:0] paddr,
  input  logic [rrgc_pkg::ApbDataW-1:0] pwdata,
  output logic [rrgc_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import rrgc_pkg::*;

  localparam int unsigned ColW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RowW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned CmpW = (ColW + 1 > WidthW) ? ColW + 1 : WidthW;
  localparam int unsigned CbW  = (ColW > BoundW) ? ColW : BoundW;
  localparam int unsigned RbW  = (RowW > BoundW) ? RowW : BoundW;

  // configuration registers
  logic [WidthW-1:0] image_width_q;
  logic [BoundW-1:0] col_first_q, col_last_q, row_first_q, row_last_q;
  logic [GainW-1:0]  gain_red_q, gain_green_q, gain_blue_q;
  reg_idx_e          reg_idx;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= WidthW'(1);
      col_first_q   <= '0;
      col_last_q    <= '0;
      row_first_q   <= '0;
      row_last_q    <= '0;
      gain_red_q    <= GAIN_ONE;
      gain_green_q  <= GAIN_ONE;
      gain_blue_q   <= GAIN_ONE;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_IMAGE_WIDTH: image_width_q <= pwdata[WidthW-1:0];
        REG_COL_FIRST:   col_first_q   <= pwdata[BoundW-1:0];
        REG_COL_LAST:    col_last_q    <= pwdata[BoundW-1:0];
        REG_ROW_FIRST:   row_first_q   <= pwdata[BoundW-1:0];
        REG_ROW_LAST:    row_last_q    <= pwdata[BoundW-1:0];
        REG_GAIN_RED:    gain_red_q    <= pwdata[GainW-1:0];
        REG_GAIN_GREEN:  gain_green_q  <= pwdata[GainW-1:0];
        REG_GAIN_BLUE:   gain_blue_q   <= pwdata[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH: prdata = ApbDataW'(image_width_q);
      REG_COL_FIRST:   prdata = ApbDataW'(col_first_q);
      REG_COL_LAST:    prdata = ApbDataW'(col_last_q);
      REG_ROW_FIRST:   prdata = ApbDataW'(row_first_q);
      REG_ROW_LAST:    prdata = ApbDataW'(row_last_q);
      REG_GAIN_RED:    prdata = ApbDataW'(gain_red_q);
      REG_GAIN_GREEN:  prdata = ApbDataW'(gain_green_q);
      REG_GAIN_BLUE:   prdata = ApbDataW'(gain_blue_q);
      default:         prdata = '0;
    endcase
  end

  // pipeline control
  logic    s1_valid_q;
  pix_in_t s1_pix_q;
  logic    s1_inside_q;
  logic    advance;
  logic    in_accept;

  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // position and region
  logic [ColW-1:0] col_q, col_d, col_cur;
  logic [RowW-1:0] row_q, row_d, row_cur;
  logic [ColW:0]   next_col;
  logic            wrap;
  logic            in_rect;

  always_comb begin
    col_cur = in_data_i.frame_start ? '0 : col_q;
    row_cur = in_data_i.frame_start ? '0 : row_q;
    next_col = (ColW+1)'(col_cur) + (ColW+1)'(1);
    wrap = (CmpW'(next_col) >= CmpW'(image_width_q)) ||
           (CmpW'(next_col) >= CmpW'(MAX_WIDTH));
    if (wrap) begin
      col_d = '0;
      row_d = (row_cur == RowW'(MAX_HEIGHT - 1)) ? '0 : row_cur + RowW'(1);
    end else begin
      col_d = next_col[ColW-1:0];
      row_d = row_cur;
    end
    in_rect = (RbW'(row_cur) >= RbW'(row_first_q)) && (RbW'(row_cur) <= RbW'(row_last_q)) &&
              (CbW'(col_cur) >= CbW'(col_first_q)) && (CbW'(col_cur) <= CbW'(col_last_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (advance || !s1_valid_q) begin
        s1_valid_q <= in_accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q    <= in_data_i;
      s1_inside_q <= in_rect;
    end
  end

  // gain stage
  logic [ChanW-1:0] blue_g, green_g, red_g;
  pix_out_t         res;
  logic             out_valid_q;
  pix_out_t         out_data_q;

  rrgc_gain u_gain_blue (
    .chan_i (s1_pix_q.blue_in),
    .gain_i (gain_blue_q),
    .chan_o (blue_g)
  );

  rrgc_gain u_gain_green (
    .chan_i (s1_pix_q.green_in),
    .gain_i (gain_green_q),
    .chan_o (green_g)
  );

  rrgc_gain u_gain_red (
    .chan_i (s1_pix_q.red_in),
    .gain_i (gain_red_q),
    .chan_o (red_g)
  );

  always_comb begin
    res.in_region = s1_inside_q;
    if (s1_inside_q) begin
      res.blue_out  = blue_g;
      res.green_out = green_g;
      res.red_out   = red_g;
    end else begin
      res.blue_out  = s1_pix_q.blue_in;
      res.green_out = s1_pix_q.green_in;
      res.red_out   = s1_pix_q.red_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> tb/region_rgb_gain_clamp_tb.sv
`timescale 1ns / 100ps

module region_rgb_gain_clamp_tb;
  import rrgc_pkg::*;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned StallLimit = 2000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  pix_in_t             in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  pix_out_t            out_data_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  region_rgb_gain_clamp dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // shadow of the register file and the position counters
  logic [WidthW-1:0] img_width = 13'd1;
  logic [BoundW-1:0] col_lo = '0, col_hi = '0, row_lo = '0, row_hi = '0;
  logic [GainW-1:0]  gain_r = GAIN_ONE, gain_g = GAIN_ONE, gain_b = GAIN_ONE;
  logic [BoundW-1:0] col_pos = '0, row_pos = '0;

  pix_in_t  pixel_q[$];
  pix_out_t graded_pix_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int n_mismatch = 0;
  int n_in = 0, n_out = 0, n_inside = 0, n_settings = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [ChanW-1:0] scale_channel(logic [ChanW-1:0] chan,
                                                     logic [GainW-1:0] gain);
    logic [31:0] v;
    logic [31:0] prod;
    v = 32'(chan);
    if (chan == '0 && gain != GAIN_ONE) begin
      v = 32'd1;
    end
    prod = (v * gain) >> 8;
    return (prod > CHAN_MAX) ? CHAN_MAX : prod[ChanW-1:0];
  endfunction

  function automatic pix_out_t grade_pixel(pix_in_t px);
    logic [BoundW-1:0] col, row;
    int unsigned       nxt;
    logic              hit;
    pix_out_t          res;
    col = px.frame_start ? '0 : col_pos;
    row = px.frame_start ? '0 : row_pos;
    hit = row >= row_lo && row <= row_hi && col >= col_lo && col <= col_hi;
    res.in_region = hit;
    res.blue_out  = hit ? scale_channel(px.blue_in, gain_b) : px.blue_in;
    res.green_out = hit ? scale_channel(px.green_in, gain_g) : px.green_in;
    res.red_out   = hit ? scale_channel(px.red_in, gain_r) : px.red_in;
    nxt = col + 1;
    if (nxt >= img_width || nxt >= MaxWidth) begin
      col_pos = '0;
      row_pos = (row + 1 >= MaxHeight) ? '0 : row + 1'b1;
    end else begin
      col_pos = BoundW'(nxt);
      row_pos = row;
    end
    return res;
  endfunction

  task automatic note_mismatch(string what, pix_out_t want, pix_out_t got);
    n_mismatch++;
    if (n_mismatch <= 10) begin
      $display("mismatch %s: expected b=%0d g=%0d r=%0d in=%0b, got b=%0d g=%0d r=%0d in=%0b",
               what, want.blue_out, want.green_out, want.red_out, want.in_region,
               got.blue_out, got.green_out, got.red_out, got.in_region);
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        graded_pix_q.push_back(grade_pixel(in_data_i));
        n_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i  <= pixel_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    pix_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_out++;
        if (out_data_o.in_region) begin
          n_inside++;
        end
        if (graded_pix_q.size() == 0) begin
          note_mismatch("unexpected transaction", '0, out_data_o);
        end else begin
          want = graded_pix_q.pop_front();
          if (want.blue_out !== out_data_o.blue_out ||
              want.green_out !== out_data_o.green_out ||
              want.red_out !== out_data_o.red_out ||
              want.in_region !== out_data_o.in_region) begin
            note_mismatch($sformatf("at result %0d", n_out), want, out_data_o);
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("timeout: no transaction for %0d cycles", StallLimit);
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [ApbDataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH: img_width = val[WidthW-1:0];
      REG_COL_FIRST:   col_lo = val[BoundW-1:0];
      REG_COL_LAST:    col_hi = val[BoundW-1:0];
      REG_ROW_FIRST:   row_lo = val[BoundW-1:0];
      REG_ROW_LAST:    row_hi = val[BoundW-1:0];
      REG_GAIN_RED:    gain_r = val[GainW-1:0];
      REG_GAIN_GREEN:  gain_g = val[GainW-1:0];
      REG_GAIN_BLUE:   gain_b = val[GainW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_region(int w, int cf, int cl, int rf, int rl,
                            int gr, int gg, int gb);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_COL_FIRST, cf);
    write_reg(REG_COL_LAST, cl);
    write_reg(REG_ROW_FIRST, rf);
    write_reg(REG_ROW_LAST, rl);
    write_reg(REG_GAIN_RED, gr);
    write_reg(REG_GAIN_GREEN, gg);
    write_reg(REG_GAIN_BLUE, gb);
    n_settings++;
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
      default: begin send_idle_pct = 8; recv_stall_pct = 8; end
    endcase
  endtask

  // sender holds off until every pixel has come back out
  task automatic drain();
    while (pixel_q.size() > 0 || in_valid_i || graded_pix_q.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [ChanW-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CHAN_MAX;
      default: return ChanW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_in_t rand_pixel(logic fs);
    return '{fs, rand_chan(), rand_chan(), rand_chan()};
  endfunction

  function automatic int rand_gain();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return GAIN_ONE;
      2: return 65535;
      3: return $urandom_range(0, 65535);
      4: return $urandom_range(128, 512);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // whole frames mostly, with stray frame starts and headless frames as noise
  task automatic queue_frames(int n);
    int left, fr_len, eff_w;
    left  = n;
    eff_w = (img_width == 0) ? 1 : ((img_width > MaxWidth) ? MaxWidth : img_width);
    while (left > 0) begin
      fr_len = eff_w * $urandom_range(1, 5);
      if (fr_len > left) begin
        fr_len = left;
      end
      for (int i = 0; i < fr_len; i++) begin
        pixel_q.push_back(rand_pixel((i == 0) ? ($urandom_range(0, 19) != 0)
                                              : ($urandom_range(0, 49) == 0)));
      end
      left -= fr_len;
    end
  endtask

  task automatic random_setting();
    int w, cf;
    case ($urandom_range(0, 9))
      0: w = 0;
      1: w = $urandom_range(13, 8191);
      2: w = MaxWidth;
      default: w = $urandom_range(1, 12);
    endcase
    cf = $urandom_range(0, 6);
    set_region(w, cf, ($urandom_range(0, 7) == 0) ? 4095 : $urandom_range(0, 10),
               $urandom_range(0, 4), ($urandom_range(0, 7) == 0) ? 4095 : $urandom_range(0, 6),
               rand_gain(), rand_gain(), rand_gain());
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // small frame, gain one on red, zero on green, maximum on blue
    set_region(4, 1, 2, 0, 1, GAIN_ONE, 0, 65535);
    set_idling(0);
    pixel_q.push_back('{1'b1, 8'd255, 8'd255, 8'd255});
    pixel_q.push_back('{1'b0, 8'd0, 8'd0, 8'd0});
    pixel_q.push_back('{1'b0, 8'd255, 8'd255, 8'd255});
    pixel_q.push_back('{1'b0, 8'd1, 8'd2, 8'd128});
    pixel_q.push_back('{1'b0, 8'd0, 8'd0, 8'd0});
    pixel_q.push_back('{1'b0, 8'd128, 8'd1, 8'd0});
    pixel_q.push_back('{1'b0, 8'd1, 8'd255, 8'd255});
    pixel_q.push_back('{1'b0, 8'd170, 8'd85, 8'd15});
    pixel_q.push_back('{1'b0, 8'd240, 8'd0, 8'd255});
    pixel_q.push_back('{1'b0, 8'd0, 8'd0, 8'd0});
    pixel_q.push_back('{1'b1, 8'd200, 8'd0, 8'd7});
    pixel_q.push_back('{1'b0, 8'd0, 8'd0, 8'd0});
    drain();

    // zero width and an empty rectangle
    set_region(0, 5, 4, 0, 4095, 512, 512, 512);
    set_idling(3);
    pixel_q.push_back('{1'b1, 8'd0, 8'd0, 8'd0});
    pixel_q.push_back('{1'b0, 8'd255, 8'd255, 8'd255});
    pixel_q.push_back('{1'b0, 8'd90, 8'd45, 8'd10});
    pixel_q.push_back('{1'b0, 8'd1, 8'd1, 8'd1});
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      random_setting();
      set_idling(ph);
      queue_frames(250);
      drain();
    end

    repeat (10) @(posedge clk_i);
    n_mismatch += graded_pix_q.size();
    $display("%0d pixels sent, %0d returned, %0d inside the region, %0d register settings",
             n_in, n_out, n_inside, n_settings);
    $display("widths 0 to 8191, empty and full rectangles, gains 0 to 65535, four idling mixes");
    if (n_mismatch == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rrgc_pkg.sv
rtl/core/rrgc_gain.sv
rtl/core/region_rgb_gain_clamp.sv
tb/region_rgb_gain_clamp_tb.sv
